// ===== hdl/rvmul_pkg.sv =====
// ----------------------------------------------------------------------------
// rvmul_pkg
// shared types and constants of the rv32i core with mul
// ----------------------------------------------------------------------------
package rvmul_pkg;

    localparam int MEM_BYTES = 65536;

    localparam logic [31:0] HALT_WORD = 32'h0ff0_0513;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_STEP    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_ILL  = 2'd2;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MUL  = 7'h01;

    localparam logic [4:0] REG_A0 = 5'd10;

    typedef enum logic [1:0] {
        K_WRITE   = 2'd0,
        K_STEP    = 2'd1,
        K_RESTART = 2'd2,
        K_NONE    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_item;

endpackage

// ===== hdl/rv32i_mul_instruction_step_top.sv =====
// ----------------------------------------------------------------------------
// rv32i_mul_instruction_step_top
// rv32i core with mul, one instruction per step word, byte-loaded memory
// ----------------------------------------------------------------------------
// sequence: write, restart and halted step words are answered from idle; a step runs
//   fetch, register read, execute and, for a load, a load state (one lane read port)
// throughput: other words one per cycle while output is free; steps do not overlap
// reset: synchronous, then a clearing pass over MEM_BYTES/4 rows (16384 by default)
//   zeroes memory while the input stays not ready
module rv32i_mul_instruction_step_top #(
    parameter int MEM_BYTES = rvmul_pkg::MEM_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_load_address,
    input  logic [7:0]  i_load_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_program_counter,
    output logic [1:0]  o_run_status,
    output logic [7:0]  o_exit_code
);

    logic             w_q_valid, w_pop, w_clearing;
    rvmul_pkg::t_item w_item;

    rvmul_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_load_address (i_load_address),
        .i_load_byte    (i_load_byte),
        .i_hold         (w_clearing),
        .o_q_valid      (w_q_valid),
        .o_item         (w_item),
        .i_pop          (w_pop)
    );

    rvmul_exec #(.MEM_BYTES(MEM_BYTES)) u_exec (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (w_q_valid),
        .i_item            (w_item),
        .o_pop             (w_pop),
        .o_clearing        (w_clearing),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_program_counter (o_program_counter),
        .o_run_status      (o_run_status),
        .o_exit_code       (o_exit_code)
    );

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_in_ready)
        else $error("word accepted during memory clear");

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !w_pop)
        else $error("queue popped during memory clear");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_run_status != 2'd3)
        else $error("bad run status");

    a_exit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_run_status != rvmul_pkg::ST_HALT) |-> o_exit_code == 8'd0)
        else $error("exit code set without halt");

endmodule

// ===== hdl/rvmul_ram.sv =====
// ----------------------------------------------------------------------------
// rvmul_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rvmul_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/rvmul_front.sv =====
// ----------------------------------------------------------------------------
// rvmul_front
// accepts words, classifies the operation and queues them for the core
// ----------------------------------------------------------------------------
module rvmul_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_operation,
    input  logic [15:0]         i_load_address,
    input  logic [7:0]          i_load_byte,
    input  logic                i_hold,
    output logic                o_q_valid,
    output rvmul_pkg::t_item    o_item,
    input  logic                i_pop
);

    rvmul_pkg::t_item r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic             push, pop;
    rvmul_pkg::t_item w_item;

    always_comb begin
        w_item.addr = i_load_address;
        w_item.data = i_load_byte;
        case (i_operation)
            rvmul_pkg::OP_WRITE:   w_item.kind = rvmul_pkg::K_WRITE;
            rvmul_pkg::OP_STEP:    w_item.kind = rvmul_pkg::K_STEP;
            rvmul_pkg::OP_RESTART: w_item.kind = rvmul_pkg::K_RESTART;
            default:               w_item.kind = rvmul_pkg::K_NONE;
        endcase
    end

    assign o_in_ready = (r_cnt != 2'd2) && !i_hold;
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_pop && (r_cnt != 2'd0);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_item     = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

// ===== hdl/rvmul_exec.sv =====
// ----------------------------------------------------------------------------
// rvmul_exec
// executes queued words: memory byte writes, restarts and instruction steps
// ----------------------------------------------------------------------------
module rvmul_exec #(
    parameter int MEM_BYTES = rvmul_pkg::MEM_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  rvmul_pkg::t_item    i_item,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [31:0]         o_program_counter,
    output logic [1:0]          o_run_status,
    output logic [7:0]          o_exit_code
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam int RW = AW - 2;
    localparam int ROWS = MEM_BYTES / 4;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DEC   = 5'b00100,
        S_EXE   = 5'b01000,
        S_LD    = 5'b10000
    } t_state;

    t_state         r_state, n_state;
    logic [RW-1:0]  r_clr, n_clr;
    logic [31:0]    r_pc, n_pc;
    logic [1:0]     r_halt, n_halt;
    logic [7:0]     r_code, n_code;
    logic [31:0]    r_rvalid, n_rvalid;
    logic [31:0]    r_ins, n_ins;
    logic           r_rs1v, n_rs1v, r_rs2v, n_rs2v;
    logic [1:0]     r_ldlo, n_ldlo;
    logic [2:0]     r_ldf3, n_ldf3;
    logic [4:0]     r_ldrd, n_ldrd;
    logic           r_out_valid, n_out_valid;
    logic [31:0]    r_opc, n_opc;
    logic [1:0]     r_ost, n_ost;
    logic [7:0]     r_ocode, n_ocode;

    logic [3:0]          lane_we, lane_re;
    logic [3:0][RW-1:0]  lane_wa, lane_ra;
    logic [3:0][7:0]     lane_wd, lane_rd;
    logic                rf_we, rf_re;
    logic [4:0]          rf_wa, rf_ra1, rf_ra2;
    logic [31:0]         rf_wd, rf_rd1, rf_rd2;

    logic        out_free, produce;
    logic [31:0] ins_f, ld_w, ld_res;
    logic [31:0] a, b;
    logic [6:0]  opc, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] immi, imms, immb, immj, immu, mul_lo;
    logic [31:0] ex_res, ex_nxt, ex_ad;
    logic        ex_wb, ex_ill, ex_ld, ex_st, taken;
    logic [4:0]  sh;

    function automatic logic [RW-1:0] row_of(input logic [AW-1:0] ad, input logic [1:0] ln);
        logic [1:0]    k;
        logic [AW-1:0] s;
        k = ln - ad[1:0];
        s = ad + AW'(k);
        return s[AW-1:2];
    endfunction

    genvar gl;
    generate
        for (gl = 0; gl < 4; gl++) begin : g_lane
            rvmul_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
                .i_clk   (i_clk),
                .i_we    (lane_we[gl]),
                .i_waddr (lane_wa[gl]),
                .i_wdata (lane_wd[gl]),
                .i_re    (lane_re[gl]),
                .i_raddr (lane_ra[gl]),
                .o_rdata (lane_rd[gl])
            );
        end
    endgenerate

    rvmul_ram #(.WIDTH(32), .DEPTH(32)) u_rf1 (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_wa), .i_wdata(rf_wd),
        .i_re(rf_re), .i_raddr(rf_ra1), .o_rdata(rf_rd1)
    );

    rvmul_ram #(.WIDTH(32), .DEPTH(32)) u_rf2 (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_wa), .i_wdata(rf_wd),
        .i_re(rf_re), .i_raddr(rf_ra2), .o_rdata(rf_rd2)
    );

    // byte gathering from the four lanes and load sign or zero extension
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ins_f[8*k +: 8] = lane_rd[2'(r_pc[1:0] + 2'(k))];
            ld_w[8*k +: 8]  = lane_rd[2'(r_ldlo + 2'(k))];
        end
        case (r_ldf3)
            3'd0:    ld_res = {{24{ld_w[7]}}, ld_w[7:0]};
            3'd1:    ld_res = {{16{ld_w[15]}}, ld_w[15:0]};
            3'd4:    ld_res = {24'd0, ld_w[7:0]};
            3'd5:    ld_res = {16'd0, ld_w[15:0]};
            default: ld_res = ld_w;
        endcase
    end

    // decode and alu
    always_comb begin
        a      = r_rs1v ? rf_rd1 : 32'd0;
        b      = r_rs2v ? rf_rd2 : 32'd0;
        opc    = r_ins[6:0];
        f3     = r_ins[14:12];
        f7     = r_ins[31:25];
        rd     = r_ins[11:7];
        immi   = {{20{r_ins[31]}}, r_ins[31:20]};
        imms   = {{20{r_ins[31]}}, r_ins[31:25], r_ins[11:7]};
        immb   = {{20{r_ins[31]}}, r_ins[7], r_ins[30:25], r_ins[11:8], 1'b0};
        immj   = {{12{r_ins[31]}}, r_ins[19:12], r_ins[20], r_ins[30:21], 1'b0};
        immu   = {r_ins[31:12], 12'd0};
        mul_lo = a * b;
        ex_res = 32'd0;
        ex_nxt = r_pc + 32'd4;
        ex_ad  = a + immi;
        ex_wb  = 1'b0;
        ex_ill = 1'b0;
        ex_ld  = 1'b0;
        ex_st  = 1'b0;
        taken  = 1'b0;
        sh     = 5'd0;
        case (opc)
            rvmul_pkg::OPC_LUI: begin
                ex_res = immu;
                ex_wb  = 1'b1;
            end
            rvmul_pkg::OPC_AUIPC: begin
                ex_res = r_pc + immu;
                ex_wb  = 1'b1;
            end
            rvmul_pkg::OPC_JAL: begin
                ex_res = r_pc + 32'd4;
                ex_wb  = 1'b1;
                ex_nxt = r_pc + immj;
            end
            rvmul_pkg::OPC_JALR: begin
                ex_ill = (f3 != 3'd0);
                ex_res = r_pc + 32'd4;
                ex_wb  = 1'b1;
                ex_nxt = (a + immi) & ~32'd1;
            end
            rvmul_pkg::OPC_BRANCH: begin
                case (f3)
                    3'd0:    taken = (a == b);
                    3'd1:    taken = (a != b);
                    3'd4:    taken = ($signed(a) < $signed(b));
                    3'd5:    taken = !($signed(a) < $signed(b));
                    3'd6:    taken = (a < b);
                    3'd7:    taken = (a >= b);
                    default: ex_ill = 1'b1;
                endcase
                if (taken) begin
                    ex_nxt = r_pc + immb;
                end
            end
            rvmul_pkg::OPC_LOAD: begin
                ex_ill = !(f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5});
                ex_ld  = 1'b1;
            end
            rvmul_pkg::OPC_STORE: begin
                ex_ad  = a + imms;
                ex_ill = (f3 > 3'd2);
                ex_st  = 1'b1;
            end
            rvmul_pkg::OPC_OPIMM: begin
                ex_wb = 1'b1;
                sh    = immi[4:0];
                case (f3)
                    3'd0: ex_res = a + immi;
                    3'd2: ex_res = {31'd0, $signed(a) < $signed(immi)};
                    3'd3: ex_res = {31'd0, a < immi};
                    3'd4: ex_res = a ^ immi;
                    3'd6: ex_res = a | immi;
                    3'd7: ex_res = a & immi;
                    3'd1: begin
                        ex_ill = (f7 != rvmul_pkg::F7_BASE);
                        ex_res = a << sh;
                    end
                    default: begin
                        if (f7 == rvmul_pkg::F7_BASE) begin
                            ex_res = a >> sh;
                        end else if (f7 == rvmul_pkg::F7_ALT) begin
                            ex_res = 32'($signed(a) >>> sh);
                        end else begin
                            ex_ill = 1'b1;
                        end
                    end
                endcase
            end
            rvmul_pkg::OPC_OP: begin
                ex_wb = 1'b1;
                sh    = b[4:0];
                if (f7 == rvmul_pkg::F7_BASE) begin
                    case (f3)
                        3'd0:    ex_res = a + b;
                        3'd1:    ex_res = a << sh;
                        3'd2:    ex_res = {31'd0, $signed(a) < $signed(b)};
                        3'd3:    ex_res = {31'd0, a < b};
                        3'd4:    ex_res = a ^ b;
                        3'd5:    ex_res = a >> sh;
                        3'd6:    ex_res = a | b;
                        default: ex_res = a & b;
                    endcase
                end else if (f7 == rvmul_pkg::F7_ALT && f3 == 3'd0) begin
                    ex_res = a - b;
                end else if (f7 == rvmul_pkg::F7_ALT && f3 == 3'd5) begin
                    ex_res = 32'($signed(a) >>> sh);
                end else if (f7 == rvmul_pkg::F7_MUL && f3 == 3'd0) begin
                    ex_res = mul_lo;
                end else begin
                    ex_ill = 1'b1;
                end
            end
            default: ex_ill = 1'b1;
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;

    // sequencer
    always_comb begin
        logic [AW-1:0] wa_b;
        logic [1:0]    k;
        n_state     = r_state;
        n_clr       = r_clr;
        n_pc        = r_pc;
        n_halt      = r_halt;
        n_code      = r_code;
        n_rvalid    = r_rvalid;
        n_ins       = r_ins;
        n_rs1v      = r_rs1v;
        n_rs2v      = r_rs2v;
        n_ldlo      = r_ldlo;
        n_ldf3      = r_ldf3;
        n_ldrd      = r_ldrd;
        lane_we     = 4'd0;
        lane_re     = 4'd0;
        lane_wa     = '0;
        lane_wd     = '0;
        lane_ra     = '0;
        rf_we       = 1'b0;
        rf_wa       = rd;
        rf_wd       = ex_res;
        rf_re       = 1'b0;
        rf_ra1      = ins_f[19:15];
        rf_ra2      = ins_f[24:20];
        o_pop       = 1'b0;
        produce     = 1'b0;
        wa_b        = AW'(32'(i_item.addr));
        k           = 2'd0;
        case (r_state)
            S_CLEAR: begin
                lane_we = 4'hF;
                for (int l = 0; l < 4; l++) begin
                    lane_wa[l] = r_clr;
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == {RW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop = 1'b1;
                    case (i_item.kind)
                        rvmul_pkg::K_WRITE: begin
                            lane_we[wa_b[1:0]] = 1'b1;
                            lane_wa[wa_b[1:0]] = wa_b[AW-1:2];
                            lane_wd[wa_b[1:0]] = i_item.data;
                            produce = 1'b1;
                        end
                        rvmul_pkg::K_RESTART: begin
                            n_rvalid = 32'd0;
                            n_pc     = 32'd0;
                            n_halt   = rvmul_pkg::ST_RUN;
                            n_code   = 8'd0;
                            produce  = 1'b1;
                        end
                        rvmul_pkg::K_STEP: begin
                            if (r_halt != rvmul_pkg::ST_RUN) begin
                                produce = 1'b1;
                            end else begin
                                lane_re = 4'hF;
                                for (int l = 0; l < 4; l++) begin
                                    lane_ra[l] = row_of(r_pc[AW-1:0], 2'(l));
                                end
                                n_state = S_DEC;
                            end
                        end
                        default: produce = 1'b1;
                    endcase
                end
            end
            S_DEC: begin
                rf_re = 1'b1;
                if (ins_f == rvmul_pkg::HALT_WORD) begin
                    rf_ra1 = rvmul_pkg::REG_A0;
                end
                n_rs1v  = r_rvalid[rf_ra1];
                n_rs2v  = r_rvalid[rf_ra2];
                n_ins   = ins_f;
                n_state = S_EXE;
            end
            S_EXE: begin
                if (r_ins == rvmul_pkg::HALT_WORD) begin
                    if (out_free) begin
                        n_halt  = rvmul_pkg::ST_HALT;
                        n_code  = a[7:0];
                        produce = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (ex_ill) begin
                    if (out_free) begin
                        n_halt  = rvmul_pkg::ST_ILL;
                        produce = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (ex_ld) begin
                    lane_re = 4'hF;
                    for (int l = 0; l < 4; l++) begin
                        lane_ra[l] = row_of(ex_ad[AW-1:0], 2'(l));
                    end
                    n_ldlo  = ex_ad[1:0];
                    n_ldf3  = f3;
                    n_ldrd  = rd;
                    n_state = S_LD;
                end else if (out_free) begin
                    if (ex_st) begin
                        for (int l = 0; l < 4; l++) begin
                            k = 2'(l) - ex_ad[1:0];
                            lane_we[l] = (f3 == 3'd0) ? (k == 2'd0) :
                                         (f3 == 3'd1) ? (k < 2'd2) : 1'b1;
                            lane_wa[l] = row_of(ex_ad[AW-1:0], 2'(l));
                            lane_wd[l] = b[8*k +: 8];
                        end
                    end else if (ex_wb && rd != 5'd0) begin
                        rf_we        = 1'b1;
                        n_rvalid[rd] = 1'b1;
                    end
                    n_pc    = ex_nxt;
                    produce = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LD: begin
                if (out_free) begin
                    rf_wa = r_ldrd;
                    rf_wd = ld_res;
                    if (r_ldrd != 5'd0) begin
                        rf_we            = 1'b1;
                        n_rvalid[r_ldrd] = 1'b1;
                    end
                    n_pc    = r_pc + 32'd4;
                    produce = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = r_out_valid && !i_out_ready;
        n_opc       = r_opc;
        n_ost       = r_ost;
        n_ocode     = r_ocode;
        if (produce) begin
            n_out_valid = 1'b1;
            n_opc       = n_pc;
            n_ost       = n_halt;
            n_ocode     = (n_halt == rvmul_pkg::ST_HALT) ? n_code : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pc        <= 32'd0;
            r_halt      <= rvmul_pkg::ST_RUN;
            r_code      <= 8'd0;
            r_rvalid    <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pc        <= n_pc;
            r_halt      <= n_halt;
            r_code      <= n_code;
            r_rvalid    <= n_rvalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins   <= n_ins;
        r_rs1v  <= n_rs1v;
        r_rs2v  <= n_rs2v;
        r_ldlo  <= n_ldlo;
        r_ldf3  <= n_ldf3;
        r_ldrd  <= n_ldrd;
        r_opc   <= n_opc;
        r_ost   <= n_ost;
        r_ocode <= n_ocode;
    end

    assign o_clearing        = (r_state == S_CLEAR);
    assign o_out_valid       = r_out_valid;
    assign o_program_counter = r_opc;
    assign o_run_status      = r_ost;
    assign o_exit_code       = r_ocode;

endmodule

// ===== tb/sv/tb_rv32i_mul_instruction_step_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rv32i_mul_instruction_step_top
// loads small rv32i programs with mul byte by byte, steps them and checks pc, status
// and exit code of every word against a behavioral core model kept here
// ----------------------------------------------------------------------------
module tb_rv32i_mul_instruction_step_top;
    import rvmul_pkg::*;

    localparam int MEMSZ = rvmul_pkg::MEM_BYTES;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [31:0] pc;
        logic [1:0]  status;
        logic [7:0]  code;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_operation = OP_WRITE;
    logic [15:0] i_load_address = '0;
    logic [7:0]  i_load_byte = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_program_counter;
    logic [1:0]  o_run_status;
    logic [7:0]  o_exit_code;

    rv32i_mul_instruction_step_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_operation(i_operation), .i_load_address(i_load_address),
        .i_load_byte(i_load_byte),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_program_counter(o_program_counter), .o_run_status(o_run_status),
        .o_exit_code(o_exit_code)
    );

    always #6 i_clk = ~i_clk;

    // core model state
    logic [31:0] cpu_regs [32];
    logic [31:0] cpu_pc;
    logic [7:0]  cpu_mem [MEMSZ];
    logic [1:0]  cpu_halt;
    logic [7:0]  cpu_code;

    t_item    pending_words [$];
    t_outcome expected_outcomes [$];
    int       mismatch_count = 0;
    int       checked_count = 0;
    int       step_count = 0;
    int       halt_count = 0;
    int       illegal_count = 0;
    bit       calm = 1'b0;
    longint   cycle_count = 0;

    function automatic logic [31:0] mem_rd(logic [31:0] a, int n);
        logic [31:0] v;
        v = '0;
        for (int k = 0; k < n; k++)
            v |= 32'(cpu_mem[(a + k) % MEMSZ]) << (8 * k);
        return v;
    endfunction

    function automatic logic [31:0] sx(logic [31:0] v, int bits);
        logic [31:0] m;
        m = 32'd1 << (bits - 1);
        v &= (m << 1) - 1;
        return (v ^ m) - m;
    endfunction

    function automatic bit run_instr();
        logic [31:0] ins, a, b, immi, nxt, res, ad, im;
        logic [6:0]  opc, f7;
        logic [2:0]  f3;
        logic [4:0]  rd, sh;
        bit          wb, t;
        ins = mem_rd(cpu_pc, 4);
        opc = ins[6:0]; f3 = ins[14:12]; f7 = ins[31:25]; rd = ins[11:7];
        a = cpu_regs[ins[19:15]]; b = cpu_regs[ins[24:20]];
        immi = sx(ins >> 20, 12);
        nxt = cpu_pc + 4; res = '0; wb = 1'b0;
        case (opc)
            OPC_LUI: begin res = ins & 32'hFFFFF000; wb = 1; end
            OPC_AUIPC: begin res = cpu_pc + (ins & 32'hFFFFF000); wb = 1; end
            OPC_JAL: begin
                im = {11'd0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                res = cpu_pc + 4; wb = 1; nxt = cpu_pc + sx(im, 21);
            end
            OPC_JALR: begin
                if (f3 != 0) return 0;
                res = cpu_pc + 4; wb = 1; nxt = (a + immi) & ~32'd1;
            end
            OPC_BRANCH: begin
                im = {19'd0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                case (f3)
                    3'd0: t = a == b;
                    3'd1: t = a != b;
                    3'd4: t = $signed(a) < $signed(b);
                    3'd5: t = $signed(a) >= $signed(b);
                    3'd6: t = a < b;
                    3'd7: t = a >= b;
                    default: return 0;
                endcase
                if (t) nxt = cpu_pc + sx(im, 13);
            end
            OPC_LOAD: begin
                ad = a + immi;
                case (f3)
                    3'd0: res = sx(mem_rd(ad, 1), 8);
                    3'd1: res = sx(mem_rd(ad, 2), 16);
                    3'd2: res = mem_rd(ad, 4);
                    3'd4: res = mem_rd(ad, 1);
                    3'd5: res = mem_rd(ad, 2);
                    default: return 0;
                endcase
                wb = 1;
            end
            OPC_STORE: begin
                ad = a + sx({20'd0, ins[31:25], ins[11:7]}, 12);
                if (f3 > 2) return 0;
                for (int k = 0; k < (1 << f3); k++)
                    cpu_mem[(ad + k) % MEMSZ] = b[8*k +: 8];
            end
            OPC_OPIMM: begin
                sh = immi[4:0];
                case (f3)
                    3'd0: res = a + immi;
                    3'd2: res = 32'($signed(a) < $signed(immi));
                    3'd3: res = 32'(a < immi);
                    3'd4: res = a ^ immi;
                    3'd6: res = a | immi;
                    3'd7: res = a & immi;
                    3'd1: begin
                        if (f7 != F7_BASE) return 0;
                        res = a << sh;
                    end
                    default: begin
                        if (f7 == F7_BASE) res = a >> sh;
                        else if (f7 == F7_ALT) res = $signed(a) >>> sh;
                        else return 0;
                    end
                endcase
                wb = 1;
            end
            OPC_OP: begin
                sh = b[4:0];
                if (f7 == F7_BASE) begin
                    case (f3)
                        3'd0: res = a + b;
                        3'd1: res = a << sh;
                        3'd2: res = 32'($signed(a) < $signed(b));
                        3'd3: res = 32'(a < b);
                        3'd4: res = a ^ b;
                        3'd5: res = a >> sh;
                        3'd6: res = a | b;
                        default: res = a & b;
                    endcase
                end else if (f7 == F7_ALT && f3 == 0) res = a - b;
                else if (f7 == F7_ALT && f3 == 5) res = $signed(a) >>> sh;
                else if (f7 == F7_MUL && f3 == 0) res = a * b;
                else return 0;
                wb = 1;
            end
            default: return 0;
        endcase
        if (wb && rd != 0) cpu_regs[rd] = res;
        cpu_pc = nxt;
        return 1;
    endfunction

    function automatic t_outcome predict_word(t_item w);
        t_outcome o;
        case (w.kind)
            K_WRITE: cpu_mem[w.addr % MEMSZ] = w.data;
            K_RESTART: begin
                foreach (cpu_regs[r]) cpu_regs[r] = '0;
                cpu_pc = '0; cpu_halt = ST_RUN; cpu_code = '0;
            end
            K_STEP: if (cpu_halt == ST_RUN) begin
                step_count++;
                if (mem_rd(cpu_pc, 4) == HALT_WORD) begin
                    cpu_halt = ST_HALT; cpu_code = cpu_regs[REG_A0][7:0]; halt_count++;
                end else if (!run_instr()) begin
                    cpu_halt = ST_ILL; illegal_count++;
                end
            end
            default: ;
        endcase
        o.pc = cpu_pc;
        o.status = cpu_halt;
        o.code = (cpu_halt == ST_HALT) ? cpu_code : 8'd0;
        return o;
    endfunction

    task automatic put_word(t_kind k, logic [15:0] a, logic [7:0] d);
        t_item w;
        w.kind = k; w.addr = a; w.data = d;
        pending_words.push_back(w);
    endtask

    task automatic put_instr(logic [15:0] a, logic [31:0] ins);
        for (int k = 0; k < 4; k++) put_word(K_WRITE, a + 16'(k), ins[8*k +: 8]);
    endtask

    function automatic logic [31:0] rand_instr();
        logic [31:0] ins;
        logic [6:0]  opcs [9];
        opcs = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD,
                 OPC_STORE, OPC_OPIMM, OPC_OP};
        ins = $urandom;
        if ($urandom_range(0, 19) != 0) ins[6:0] = opcs[$urandom_range(0, 8)];
        if (ins[6:0] == OPC_OP) begin
            case ($urandom_range(0, 3))
                0: ins[31:25] = F7_MUL;
                1: ins[31:25] = F7_ALT;
                2: ins[31:25] = F7_BASE;
                default: ;
            endcase
        end
        if (ins[6:0] == OPC_OPIMM && ins[13:12] == 2'b01 && $urandom_range(0, 3) != 0)
            ins[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
        // mostly small forward jumps and branches so programs stay in the loaded area
        if (ins[6:0] inside {OPC_JAL, OPC_BRANCH} && $urandom_range(0, 3) != 0) begin
            ins[31] = 1'b0; ins[30:25] = '0; ins[19:12] = '0;
        end
        if (ins[6:0] == OPC_JALR && $urandom_range(0, 1)) ins[14:12] = 3'd0;
        return ins;
    endfunction

    initial begin
        foreach (cpu_regs[r]) cpu_regs[r] = '0;
        foreach (cpu_mem[m]) cpu_mem[m] = '0;
        cpu_pc = '0; cpu_halt = ST_RUN; cpu_code = '0;

        // directed: mul, halt with a0, illegal op, wraps, ignored op
        put_instr(16'h0000, 32'h0070_0093);          // addi x1, x0, 7
        put_instr(16'h0004, 32'hFFF0_0113);          // addi x2, x0, -1
        put_instr(16'h0008, 32'h0220_8533);          // mul a0, x1, x2
        put_instr(16'h000C, 32'h0ff0_0513);          // halt
        for (int s = 0; s < 5; s++) put_word(K_STEP, '0, '0);
        put_word(K_NONE, 16'hFFFF, 8'hFF);
        put_word(K_RESTART, '0, '0);
        put_word(K_WRITE, 16'hFFFF, 8'hFF);
        put_word(K_WRITE, 16'h0010, 8'h73);          // ecall
        put_instr(16'h0000, 32'h0100_006F);          // jal x0, +16
        put_word(K_STEP, '0, '0);
        put_word(K_STEP, '0, '0);
        put_word(K_STEP, '0, '0);
        put_word(K_RESTART, '0, '0);

        // random programs
        while (pending_words.size() < 500) begin
            int n;
            n = $urandom_range(3, 10);
            for (int i = 0; i < n; i++) put_instr(16'(4 * i), rand_instr());
            if ($urandom_range(0, 1)) put_instr(16'(4 * n), HALT_WORD);
            if ($urandom_range(0, 4) == 0)
                put_word(t_kind'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
            for (int i = 0; i < n + 3; i++) put_word(K_STEP, '0, '0);
            put_word(K_RESTART, '0, '0);
        end
        put_word(K_WRITE, 16'hFFFF, 8'h00);
        put_word(K_WRITE, 16'h0000, 8'h00);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        calm <= (cycle_count % 4000) > 3000;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_outcomes.push_back(predict_word(pending_words.pop_front()));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_words.size() > 0 &&
                    (calm || $urandom_range(0, 99) >= 17)) begin
                    i_in_valid <= 1'b1;
                    i_operation <= pending_words[0].kind;
                    i_load_address <= pending_words[0].addr;
                    i_load_byte <= pending_words[0].data;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= calm || ($urandom_range(0, 99) >= 17);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_outcome e;
            if (expected_outcomes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected word pc=%h", o_program_counter);
            end else begin
                e = expected_outcomes.pop_front();
                checked_count++;
                if (e.pc !== o_program_counter || e.status !== o_run_status ||
                    e.code !== o_exit_code) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("word %0d: expected pc=%h st=%0d code=%h, got pc=%h st=%0d code=%h",
                            checked_count, e.pc, e.status, e.code,
                            o_program_counter, o_run_status, o_exit_code);
                end
            end
        end
    end

    initial begin
        wait (i_rst_n);
        while (pending_words.size() != 0 || i_in_valid || expected_outcomes.size() != 0) begin
            @(posedge i_clk);
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout with %0d words outstanding", expected_outcomes.size());
                $display("rv32i_mul_instruction_step_top: mismatch");
                $finish;
            end
        end
        repeat (20) @(posedge i_clk);
        $display("checked %0d words, %0d instructions run, %0d normal halts, %0d illegal",
            checked_count, step_count, halt_count, illegal_count);
        if (mismatch_count == 0 && expected_outcomes.size() == 0)
            $display("rv32i_mul_instruction_step_top: match");
        else
            $display("rv32i_mul_instruction_step_top: mismatch");
        $finish;
    end
endmodule
